// File: rtl/cbf_pkg.sv
// ============================================================================
// cbf_pkg
// Shared types and constants for the cubic Bezier flattener.
// ============================================================================
package cbf_pkg;

    localparam int COORD_W = 24;
    localparam int TOL_W   = 16;
    localparam int PH_W    = 23;
    localparam int POINT_W = 2 * COORD_W;
    localparam int ROW_W   = 4 * POINT_W;

    // reciprocal of three for 24-bit magnitudes: (2^25 + 1) / 3
    localparam logic [23:0] RECIP3 = 24'hAAAAAB;
    localparam int          RECIP3_SHIFT = 25;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd26;

    localparam logic CFG_TOL = 1'b0;
    localparam logic CFG_PH  = 1'b1;

    localparam logic CMD_MOVE = 1'b0;
    localparam logic CMD_LINE = 1'b1;

    typedef logic [4:0] dp_op_t;
    localparam dp_op_t OP_NONE   = 5'd0;
    localparam dp_op_t OP_LOAD   = 5'd1;
    localparam dp_op_t OP_MID1   = 5'd2;
    localparam dp_op_t OP_MID2   = 5'd3;
    localparam dp_op_t OP_MID3   = 5'd4;
    localparam dp_op_t OP_DIFF   = 5'd5;
    localparam dp_op_t OP_PROD   = 5'd6;
    localparam dp_op_t OP_SUM    = 5'd7;
    localparam dp_op_t OP_ABS    = 5'd8;
    localparam dp_op_t OP_MUL    = 5'd9;
    localparam dp_op_t OP_ACC    = 5'd10;
    localparam dp_op_t OP_PUSH   = 5'd11;
    localparam dp_op_t OP_POP_RD = 5'd12;
    localparam dp_op_t OP_POP_LD = 5'd13;
    localparam dp_op_t OP_ESEL   = 5'd14;
    localparam dp_op_t OP_EMUL   = 5'd15;
    localparam dp_op_t OP_EPUSH  = 5'd16;
    localparam dp_op_t OP_FLUSH  = 5'd17;

    typedef logic [1:0] pt_src_t;
    localparam pt_src_t SRC_P0    = 2'd0;
    localparam pt_src_t SRC_P3    = 2'd1;
    localparam pt_src_t SRC_START = 2'd2;

    typedef struct packed {
        dp_op_t  op;
        pt_src_t src;
    } dp_cmd_t;

    typedef struct packed {
        logic too_far;
        logic push_ok;
        logic flush_ok;
    } dp_stat_t;

endpackage

// File: rtl/cbf_ctrl.sv
// ============================================================================
// cbf_ctrl
// Sequencer: walks the subdivision tree depth-first and drives the datapath.
// ============================================================================
module cbf_ctrl
    import cbf_pkg::*;
#(
    parameter int MAX_DEPTH = 5,
    parameter int IDX_W     = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic             s_axis_tlast,
    input  logic [1:0]       s_axis_tuser,
    output dp_cmd_t          cmd,
    output logic [IDX_W-1:0] stk_idx,
    input  dp_stat_t         stat
);

    localparam int SP_W  = $clog2(MAX_DEPTH + 1);
    localparam int LVL_W = $clog2(MAX_DEPTH + 1);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_MID1   = 5'd1;
    localparam logic [4:0] S_MID2   = 5'd2;
    localparam logic [4:0] S_MID3   = 5'd3;
    localparam logic [4:0] S_DIFF   = 5'd4;
    localparam logic [4:0] S_PROD   = 5'd5;
    localparam logic [4:0] S_SUM    = 5'd6;
    localparam logic [4:0] S_ABS    = 5'd7;
    localparam logic [4:0] S_MUL    = 5'd8;
    localparam logic [4:0] S_ACC    = 5'd9;
    localparam logic [4:0] S_CMP    = 5'd10;
    localparam logic [4:0] S_POP    = 5'd11;
    localparam logic [4:0] S_POPLD  = 5'd12;
    localparam logic [4:0] S_ESEL   = 5'd13;
    localparam logic [4:0] S_EMUL   = 5'd14;
    localparam logic [4:0] S_EPUSH  = 5'd15;
    localparam logic [4:0] S_FINISH = 5'd16;

    logic [4:0]      state_reg, state_next;
    logic [4:0]      ret_reg, ret_next;
    pt_src_t         src_reg, src_next;
    logic            close_reg, close_next;
    logic [SP_W-1:0] sp_reg, sp_next;
    logic [LVL_W-1:0] level_reg, level_next;
    logic [LVL_W-1:0] dstk [MAX_DEPTH];
    logic            dstk_we;
    logic [SP_W-1:0] sp_dec;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign sp_dec        = sp_reg - 1'b1;

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        src_next   = src_reg;
        close_next = close_reg;
        sp_next    = sp_reg;
        level_next = level_reg;
        dstk_we    = 1'b0;
        cmd.op     = OP_NONE;
        cmd.src    = src_reg;
        stk_idx    = sp_reg[IDX_W-1:0];
        unique case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.op     = OP_LOAD;
                    close_next = s_axis_tlast & s_axis_tuser[1];
                    sp_next    = '0;
                    level_next = '0;
                    if (s_axis_tuser[0]) begin
                        src_next   = SRC_P0;
                        ret_next   = S_MID1;
                        state_next = S_ESEL;
                    end else begin
                        state_next = S_MID1;
                    end
                end
            end
            S_MID1: begin cmd.op = OP_MID1; state_next = S_MID2; end
            S_MID2: begin cmd.op = OP_MID2; state_next = S_MID3; end
            S_MID3: begin cmd.op = OP_MID3; state_next = S_DIFF; end
            S_DIFF: begin cmd.op = OP_DIFF; state_next = S_PROD; end
            S_PROD: begin cmd.op = OP_PROD; state_next = S_SUM;  end
            S_SUM:  begin cmd.op = OP_SUM;  state_next = S_ABS;  end
            S_ABS:  begin cmd.op = OP_ABS;  state_next = S_MUL;  end
            S_MUL:  begin cmd.op = OP_MUL;  state_next = S_ACC;  end
            S_ACC:  begin cmd.op = OP_ACC;  state_next = S_CMP;  end
            S_CMP: begin
                if (!stat.too_far) begin
                    src_next   = SRC_P3;
                    ret_next   = S_POP;
                    state_next = S_ESEL;
                end else if (level_reg < LVL_W'(MAX_DEPTH) && sp_reg < SP_W'(MAX_DEPTH)) begin
                    cmd.op     = OP_PUSH;
                    dstk_we    = 1'b1;
                    sp_next    = sp_reg + 1'b1;
                    level_next = level_reg + 1'b1;
                    state_next = S_MID1;
                end else begin
                    state_next = S_POP;
                end
            end
            S_POP: begin
                if (sp_reg == '0) begin
                    if (close_reg) begin
                        src_next   = SRC_START;
                        ret_next   = S_FINISH;
                        state_next = S_ESEL;
                    end else begin
                        state_next = S_FINISH;
                    end
                end else begin
                    cmd.op     = OP_POP_RD;
                    stk_idx    = sp_dec[IDX_W-1:0];
                    sp_next    = sp_dec;
                    level_next = dstk[sp_dec[IDX_W-1:0]];
                    state_next = S_POPLD;
                end
            end
            S_POPLD: begin cmd.op = OP_POP_LD; state_next = S_MID1; end
            S_ESEL:  begin cmd.op = OP_ESEL;   state_next = S_EMUL; end
            S_EMUL:  begin cmd.op = OP_EMUL;   state_next = S_EPUSH; end
            S_EPUSH: begin
                if (stat.push_ok) begin
                    cmd.op     = OP_EPUSH;
                    state_next = ret_reg;
                end
            end
            S_FINISH: begin
                if (stat.flush_ok) begin
                    cmd.op     = OP_FLUSH;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sp_reg    <= '0;
            level_reg <= '0;
            close_reg <= 1'b0;
            ret_reg   <= S_IDLE;
            src_reg   <= SRC_P0;
        end else begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            level_reg <= level_next;
            close_reg <= close_next;
            ret_reg   <= ret_next;
            src_reg   <= src_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (dstk_we) begin
            dstk[sp_reg[IDX_W-1:0]] <= level_next;
        end
    end

endmodule

// File: rtl/cbf_datapath.sv
// ============================================================================
// cbf_datapath
// Point registers, piece stack, flatness arithmetic and result staging.
// ============================================================================
module cbf_datapath
    import cbf_pkg::*;
#(
    parameter int MAX_DEPTH = 5,
    parameter int IDX_W     = 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  dp_cmd_t          cmd,
    input  logic [IDX_W-1:0] stk_idx,
    output dp_stat_t         stat,
    input  logic [ROW_W-1:0] s_axis_tdata,
    input  logic             cfg_valid,
    input  logic [0:0]       cfg_index,
    input  logic [PH_W-1:0]  cfg_data,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [47:0]      m_axis_tdata,
    output logic             m_axis_tuser,
    output logic             m_axis_tlast
);

    typedef logic signed [COORD_W-1:0] crd_t;
    typedef logic signed [COORD_W:0]   dif_t;
    typedef logic signed [2*COORD_W+1:0] prd_t;
    typedef logic signed [2*COORD_W+2:0] sum_t;

    crd_t px [4];
    crd_t py [4];
    crd_t x12, y12, x23, y23, x34, y34, x123, y123, x234, y234, xm, ym;
    dif_t pqx, pqy, dx, dy, ex, ey;
    prd_t pr_pqx2, pr_pqy2, pr_n1, pr_n2, pr_d0x, pr_d0y, pr_d3x, pr_d3y, pr_c1, pr_c2;
    sum_t d_reg, num_reg, dist0_reg, dist3_reg, cross_reg;
    logic [49:0] cabs_reg;
    logic [49:0] chh_reg, chl_reg, cll_reg;
    logic [56:0] th_reg, tl_reg;
    logic [99:0] c2_reg;
    logic [81:0] t2d_reg;

    logic [TOL_W-1:0]   tol_reg;
    logic [2*TOL_W-1:0] tol2_reg;
    logic [PH_W-1:0]    ph_reg;
    crd_t start_x_reg, start_y_reg;

    logic [ROW_W-1:0] stack_mem [MAX_DEPTH];
    logic [ROW_W-1:0] stack_rd;

    crd_t        ex_sel, ey_sel;
    logic        ecmd_reg;
    logic [22:0] qx_reg, qy_reg;
    logic        sx_reg, sy_reg;

    logic        fcmd_reg;
    crd_t        fx_reg, fy_reg;

    logic        hv_reg;
    logic        hcmd_reg;
    crd_t        hx_reg, hy_reg;

    logic        mv_reg;
    logic        mcmd_reg, mlast_reg;
    crd_t        mx_reg, my_reg;

    logic        out_free;
    logic        load_m;

    function automatic crd_t mid_pt(input crd_t a, input crd_t b);
        logic signed [COORD_W:0] s;
        s = COORD_W'(0) + {a[COORD_W-1], a} + {b[COORD_W-1], b};
        return s[COORD_W:1];
    endfunction

    function automatic logic [22:0] div3_mag(input crd_t v);
        logic [23:0] a;
        logic [47:0] p;
        a = v[COORD_W-1] ? 24'(-v) : 24'(v);
        p = a * RECIP3;
        return p[RECIP3_SHIFT +: 23];
    endfunction

    assign out_free = !mv_reg || m_axis_tready;
    assign load_m   = ((cmd.op == OP_EPUSH) || (cmd.op == OP_FLUSH)) && hv_reg;

    // flatness decision on registered sums and products
    always_comb begin
        logic near_end0, near_end3;
        near_end0 = num_reg[2*COORD_W+2] || (num_reg == '0) || (d_reg == '0);
        near_end3 = (num_reg >= d_reg);
        if (near_end0) begin
            stat.too_far = $unsigned(dist0_reg) > {19'd0, tol2_reg};
        end else if (near_end3) begin
            stat.too_far = $unsigned(dist3_reg) > {19'd0, tol2_reg};
        end else begin
            stat.too_far = c2_reg > {18'd0, t2d_reg};
        end
        stat.push_ok  = !hv_reg || out_free;
        stat.flush_ok = !hv_reg || out_free;
    end

    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = {my_reg, mx_reg};
    assign m_axis_tuser  = mcmd_reg;
    assign m_axis_tlast  = mlast_reg;

    always_comb begin
        unique case (cmd.src)
            SRC_P0:    begin ex_sel = px[0];       ey_sel = py[0];       end
            SRC_P3:    begin ex_sel = px[3];       ey_sel = py[3];       end
            SRC_START: begin ex_sel = start_x_reg; ey_sel = start_y_reg; end
            default:   begin ex_sel = px[0];       ey_sel = py[0];       end
        endcase
    end

    // result formatting
    crd_t                oxv, qys;
    logic signed [25:0]  oy_full;
    crd_t                oyv;
    always_comb begin
        oxv     = sx_reg ? -crd_t'({1'b0, qx_reg}) : crd_t'({1'b0, qx_reg});
        qys     = sy_reg ? -crd_t'({1'b0, qy_reg}) : crd_t'({1'b0, qy_reg});
        oy_full = $signed({3'b000, ph_reg}) - 26'(qys);
        if (oy_full > 26'sd8388607) begin
            oyv = 24'h7FFFFF;
        end else if (oy_full < -26'sd8388608) begin
            oyv = 24'h800000;
        end else begin
            oyv = oy_full[COORD_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        tol2_reg <= tol_reg * tol_reg;
        unique case (cmd.op)
            OP_LOAD: begin
                for (int i = 0; i < 4; i++) begin
                    px[i] <= s_axis_tdata[i*POINT_W +: COORD_W];
                    py[i] <= s_axis_tdata[i*POINT_W+COORD_W +: COORD_W];
                end
            end
            OP_MID1: begin
                x12 <= mid_pt(px[0], px[1]); y12 <= mid_pt(py[0], py[1]);
                x23 <= mid_pt(px[1], px[2]); y23 <= mid_pt(py[1], py[2]);
                x34 <= mid_pt(px[2], px[3]); y34 <= mid_pt(py[2], py[3]);
            end
            OP_MID2: begin
                x123 <= mid_pt(x12, x23); y123 <= mid_pt(y12, y23);
                x234 <= mid_pt(x23, x34); y234 <= mid_pt(y23, y34);
            end
            OP_MID3: begin
                xm <= mid_pt(x123, x234); ym <= mid_pt(y123, y234);
            end
            OP_DIFF: begin
                pqx <= dif_t'(px[3]) - dif_t'(px[0]);
                pqy <= dif_t'(py[3]) - dif_t'(py[0]);
                dx  <= dif_t'(xm) - dif_t'(px[0]);
                dy  <= dif_t'(ym) - dif_t'(py[0]);
                ex  <= dif_t'(xm) - dif_t'(px[3]);
                ey  <= dif_t'(ym) - dif_t'(py[3]);
            end
            OP_PROD: begin
                pr_pqx2 <= pqx * pqx;
                pr_pqy2 <= pqy * pqy;
                pr_n1   <= pqx * dx;
                pr_n2   <= pqy * dy;
                pr_d0x  <= dx * dx;
                pr_d0y  <= dy * dy;
                pr_d3x  <= ex * ex;
                pr_d3y  <= ey * ey;
                pr_c1   <= pqx * dy;
                pr_c2   <= pqy * dx;
            end
            OP_SUM: begin
                d_reg     <= sum_t'(pr_pqx2) + sum_t'(pr_pqy2);
                num_reg   <= sum_t'(pr_n1) + sum_t'(pr_n2);
                dist0_reg <= sum_t'(pr_d0x) + sum_t'(pr_d0y);
                dist3_reg <= sum_t'(pr_d3x) + sum_t'(pr_d3y);
                cross_reg <= sum_t'(pr_c1) - sum_t'(pr_c2);
            end
            OP_ABS: begin
                cabs_reg <= cross_reg[2*COORD_W+2] ? 50'(-cross_reg) : 50'(cross_reg);
            end
            OP_MUL: begin
                chh_reg <= cabs_reg[49:25] * cabs_reg[49:25];
                chl_reg <= cabs_reg[49:25] * cabs_reg[24:0];
                cll_reg <= cabs_reg[24:0] * cabs_reg[24:0];
                th_reg  <= tol2_reg * d_reg[49:25];
                tl_reg  <= tol2_reg * d_reg[24:0];
            end
            OP_ACC: begin
                c2_reg  <= {chh_reg, 50'd0} + {24'd0, chl_reg, 26'd0}
                         + {50'd0, cll_reg};
                t2d_reg <= {th_reg, 25'd0} + {25'd0, tl_reg};
            end
            OP_PUSH: begin
                stack_mem[stk_idx] <= {py[3], px[3], y34, x34, y234, x234, ym, xm};
                px[1] <= x12;  py[1] <= y12;
                px[2] <= x123; py[2] <= y123;
                px[3] <= xm;   py[3] <= ym;
            end
            OP_POP_RD: begin
                stack_rd <= stack_mem[stk_idx];
            end
            OP_POP_LD: begin
                for (int i = 0; i < 4; i++) begin
                    px[i] <= stack_rd[i*POINT_W +: COORD_W];
                    py[i] <= stack_rd[i*POINT_W+COORD_W +: COORD_W];
                end
            end
            OP_ESEL: begin
                ecmd_reg <= (cmd.src == SRC_P0) ? CMD_MOVE : CMD_LINE;
                qx_reg   <= div3_mag(ex_sel);
                qy_reg   <= div3_mag(ey_sel);
                sx_reg   <= ex_sel[COORD_W-1];
                sy_reg   <= ey_sel[COORD_W-1];
            end
            OP_EMUL: begin
                fcmd_reg <= ecmd_reg;
                fx_reg   <= oxv;
                fy_reg   <= oyv;
            end
            OP_EPUSH: begin
                hcmd_reg <= fcmd_reg;
                hx_reg   <= fx_reg;
                hy_reg   <= fy_reg;
            end
            default: ;
        endcase
    end

    // control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg     <= TOL_RESET;
            ph_reg      <= '0;
            start_x_reg <= '0;
            start_y_reg <= '0;
            hv_reg      <= 1'b0;
            mv_reg      <= 1'b0;
            mcmd_reg    <= CMD_MOVE;
            mlast_reg   <= 1'b0;
            mx_reg      <= '0;
            my_reg      <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_TOL: tol_reg <= cfg_data[TOL_W-1:0];
                    CFG_PH:  ph_reg  <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.op == OP_ESEL && cmd.src == SRC_P0) begin
                start_x_reg <= px[0];
                start_y_reg <= py[0];
            end
            if (cmd.op == OP_EPUSH) begin
                hv_reg <= 1'b1;
            end else if (cmd.op == OP_FLUSH) begin
                hv_reg <= 1'b0;
            end
            if (load_m) begin
                mv_reg    <= 1'b1;
                mcmd_reg  <= hcmd_reg;
                mx_reg    <= hx_reg;
                my_reg    <= hy_reg;
                mlast_reg <= (cmd.op == OP_FLUSH);
            end else if (mv_reg && m_axis_tready) begin
                mv_reg <= 1'b0;
            end
        end
    end

endmodule

// File: rtl/cubic_bezier_flattener.sv
// ============================================================================
// cubic_bezier_flattener
// Adaptive midpoint-subdivision flattener for cubic Bezier segments.
// ============================================================================
// Each flatness test steps through the shared arithmetic path, a pop reloads
// a deferred piece from the stack, each emitted point is divided by three,
// formatted and pushed, waiting while the output is held. Up to 2^(MAX_DEPTH+1)-1
// tests per item, one item at a time: the next is taken once its last word
// moves to the output register. Reset (aresetn low, synchronous) clears control,
// the path start, tolerance to 26 and page height to 0, not the piece stack.
module cubic_bezier_flattener
    import cbf_pkg::*;
#(
    parameter int MAX_DEPTH = 5
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
    input  logic [ROW_W-1:0]  s_axis_tdata,
    // first_segment, path_closed
    input  logic [1:0]        s_axis_tuser,
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // out_x, out_y
    output logic [47:0]       m_axis_tdata,
    // command
    output logic              m_axis_tuser,
    output logic              m_axis_tlast,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [0:0]        cfg_index,
    input  logic [PH_W-1:0]   cfg_data
);

    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [IDX_W-1:0] stk_idx;

    assign cfg_ready = 1'b1;

    cbf_ctrl #(
        .MAX_DEPTH (MAX_DEPTH),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .cmd           (cmd),
        .stk_idx       (stk_idx),
        .stat          (stat)
    );

    cbf_datapath #(
        .MAX_DEPTH (MAX_DEPTH),
        .IDX_W     (IDX_W)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stk_idx       (stk_idx),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: rtl/cbf_checker.sv
// ============================================================================
// cbf_checker
// Port-level checks for the cubic Bezier flattener.
// ============================================================================
module cbf_checker
    import cbf_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [47:0]       m_axis_tdata,
    input logic              m_axis_tuser,
    input logic              m_axis_tlast
);

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output word valid right after reset");

    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_axis_tready)
        else $error("input not ready right after reset");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken while an item is in work");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

endmodule

bind cubic_bezier_flattener cbf_checker u_cbf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
